// ===== rtl/core/stereo_tape_saturator_assert.svh =====
// Assertion macros for the stereo tape saturator.
// Included by files that check their own logic; needs no package.
`ifndef STEREO_TAPE_SATURATOR_ASSERT_SVH
`define STEREO_TAPE_SATURATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sts assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sts assertion failed");
`else
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/sts_pkg.sv =====
// Shared constants, types and helper function for the stereo tape saturator.
// No dependencies; imported by sts_lane, sts_merge and the top level.
package sts_pkg;

	// Sample and knob formats
	localparam int SAMPLE_BITS = 24;
	localparam int KNOB_BITS   = 16;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;

	localparam longint UNITY  = longint'(1) << FRAC_BITS;
	localparam longint BIAS_Q = (UNITY + 5) / 10;

	// Low-pass coefficient 0.42 in Q0.16
	localparam int TONE_Q16   = 27525;
	localparam int TONE_SHIFT = 16;

	// Drive gain 1+6*drive, Q.KNOB_BITS, below 7*2^KNOB_BITS
	localparam int GAIN_W = KNOB_BITS + 3;

	// Output gain (3*2^K + 12*level + 5) / 10, below 1.5*2^K
	localparam int     OG_W    = KNOB_BITS + 1;
	localparam int     OGN_W   = KNOB_BITS + 4;
	localparam int     OGK_W   = OGN_W - 2;
	localparam longint OG_BASE = 3 * (longint'(1) << KNOB_BITS) + 5;
	localparam longint OG_DIV  = 10;
	localparam longint DIV10_K = (longint'(1) << OGN_W) / OG_DIV;

	// Datapath widths
	localparam int D_W     = SAMPLE_BITS + 4;
	localparam int LP_W    = SAMPLE_BITS + 2;
	localparam int DIFF_W  = SAMPLE_BITS + 3;
	localparam int MUL_A_W = SAMPLE_BITS + 4;
	localparam int MUL_B_W = SAMPLE_BITS + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_LEVEL  = 2'd2;

	// Lane control from the top level
	typedef struct packed {
		logic start;
		logic take;
	} sts_lane_ctl_t;

	// Lane status back to the top level
	typedef struct packed {
		logic busy;
		logic done;
	} sts_lane_stat_t;

	// Load selects for the output stage
	typedef struct packed {
		logic lane_load;
		logic pass_load;
	} sts_merge_ctl_t;

	// Cubic shaper on a non-negative magnitude, evaluated at elaboration
	function automatic longint shape_mag(longint m);
		longint m2;
		longint y;
		m2 = (m * m) >>> FRAC_BITS;
		y  = m + ((m * (UNITY - m2)) >>> (FRAC_BITS + 1));
		return y;
	endfunction

	localparam longint SHAPE_BIAS = shape_mag(BIAS_Q);

endpackage

// ===== rtl/core/sts_lane.sv =====
// One channel of the saturator: drive, cubic shaper, one-pole low-pass, level.
// Uses sts_pkg. A single multiplier is shared over the steps of a small sequencer.
module sts_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sts_pkg::sts_lane_ctl_t               ctl,
	input  logic signed [sts_pkg::SAMPLE_BITS-1:0] x,
	input  logic        [sts_pkg::GAIN_W-1:0]    gain,
	input  logic        [sts_pkg::OG_W-1:0]      og,
	output sts_pkg::sts_lane_stat_t              stat,
	output logic signed [sts_pkg::SAMPLE_BITS-1:0] y
);
	import sts_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLIP  = 4'd1;
	localparam logic [3:0] ST_SQ    = 4'd2;
	localparam logic [3:0] ST_SUB   = 4'd3;
	localparam logic [3:0] ST_CUBE  = 4'd4;
	localparam logic [3:0] ST_SHAPE = 4'd5;
	localparam logic [3:0] ST_DIFF  = 4'd6;
	localparam logic [3:0] ST_TONE  = 4'd7;
	localparam logic [3:0] ST_ACC   = 4'd8;
	localparam logic [3:0] ST_LEVEL = 4'd9;
	localparam logic [3:0] ST_SAT   = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(UNITY - 1);
	localparam logic signed [PROD_W-1:0] SAT_MIN = PROD_W'(-UNITY);

	logic [3:0]                      state_q;
	logic signed [PROD_W-1:0]        p_q;
	logic [SAMPLE_BITS-1:0]          m_q;
	logic                            neg_q;
	logic [SAMPLE_BITS-1:0]          t_q;
	logic signed [LP_W-1:0]          s_q;
	logic signed [DIFF_W-1:0]        diff_q;
	logic signed [LP_W-1:0]          lp_q;
	logic signed [SAMPLE_BITS-1:0]   y_q;

	logic signed [MUL_A_W-1:0]       mul_a;
	logic signed [MUL_B_W-1:0]       mul_b;
	logic                            mul_en;
	logic signed [D_W-1:0]           drv;
	logic [D_W-1:0]                  mag;
	logic [SAMPLE_BITS-1:0]          m2;
	logic [SAMPLE_BITS:0]            shp_y;
	logic signed [LP_W-1:0]          shp_v;
	logic signed [LP_W-1:0]          shp_s;
	logic signed [PROD_W-1:0]        tone_sum;
	logic signed [PROD_W-1:0]        lvl_sum;
	logic signed [PROD_W-1:0]        lvl_r;

	// Multiplier operand select per step
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mul_a  = MUL_A_W'(x);
				mul_b  = $signed(MUL_B_W'(gain));
				mul_en = ctl.start;
			end
			ST_SQ: begin
				mul_a  = $signed(MUL_A_W'(m_q));
				mul_b  = $signed(MUL_B_W'(m_q));
				mul_en = 1'b1;
			end
			ST_CUBE: begin
				mul_a  = $signed(MUL_A_W'(m_q));
				mul_b  = $signed(MUL_B_W'(t_q));
				mul_en = 1'b1;
			end
			ST_TONE: begin
				mul_a  = MUL_A_W'(diff_q);
				mul_b  = MUL_B_W'(TONE_Q16);
				mul_en = 1'b1;
			end
			ST_LEVEL: begin
				mul_a  = MUL_A_W'(lp_q);
				mul_b  = $signed(MUL_B_W'(og));
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Driven value plus bias, then magnitude clamped to unity
	assign drv = D_W'(p_q >>> KNOB_BITS) + D_W'(BIAS_Q);
	assign mag = drv[D_W-1] ? D_W'(-drv) : D_W'(drv);

	// Square of the magnitude back in sample format
	assign m2 = p_q[2*FRAC_BITS:FRAC_BITS];

	// m + m*(1-m^2)/2, sign restored, shaped bias removed
	assign shp_y = (SAMPLE_BITS+1)'(m_q) + (SAMPLE_BITS+1)'(p_q[2*FRAC_BITS:FRAC_BITS+1]);
	assign shp_v = $signed(LP_W'(shp_y));
	assign shp_s = neg_q ? -shp_v : shp_v;

	// Rounded low-pass increment and rounded level product
	assign tone_sum = p_q + PROD_W'(longint'(1) << (TONE_SHIFT - 1));
	assign lvl_sum  = p_q + PROD_W'(longint'(1) << (KNOB_BITS - 1));
	assign lvl_r    = lvl_sum >>> KNOB_BITS;

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lp_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start)
						state_q <= ST_CLIP;
				end
				ST_CLIP:  state_q <= ST_SQ;
				ST_SQ:    state_q <= ST_SUB;
				ST_SUB:   state_q <= ST_CUBE;
				ST_CUBE:  state_q <= ST_SHAPE;
				ST_SHAPE: state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_TONE;
				ST_TONE:  state_q <= ST_ACC;
				ST_ACC: begin
					lp_q    <= lp_q + LP_W'(tone_sum >>> TONE_SHIFT);
					state_q <= ST_LEVEL;
				end
				ST_LEVEL: state_q <= ST_SAT;
				ST_SAT:   state_q <= ST_DONE;
				ST_DONE: begin
					if (ctl.take)
						state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (mul_en)
			p_q <= mul_a * mul_b;
		if (state_q == ST_CLIP) begin
			neg_q <= drv[D_W-1];
			m_q   <= (mag > D_W'(UNITY)) ? SAMPLE_BITS'(UNITY) : mag[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_SUB)
			t_q <= SAMPLE_BITS'(UNITY) - m2;
		if (state_q == ST_SHAPE)
			s_q <= shp_s - LP_W'(SHAPE_BIAS);
		if (state_q == ST_DIFF)
			diff_q <= DIFF_W'(s_q) - DIFF_W'(lp_q);
		if (state_q == ST_SAT) begin
			if (lvl_r > SAT_MAX)
				y_q <= SAMPLE_BITS'(SAT_MAX);
			else if (lvl_r < SAT_MIN)
				y_q <= SAMPLE_BITS'(SAT_MIN);
			else
				y_q <= lvl_r[SAMPLE_BITS-1:0];
		end
	end

	assign stat.busy = (state_q != ST_IDLE) && (state_q != ST_DONE);
	assign stat.done = (state_q == ST_DONE);
	assign y         = y_q;

endmodule

// ===== rtl/core/sts_merge.sv =====
// Output stage: joins the two lane results, or the bypassed frame, into one request.
// Uses sts_pkg for widths and the load-select struct.
module sts_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sts_pkg::sts_merge_ctl_t              ctl,
	input  logic signed [sts_pkg::SAMPLE_BITS-1:0] lane_left,
	input  logic signed [sts_pkg::SAMPLE_BITS-1:0] lane_right,
	input  logic signed [sts_pkg::SAMPLE_BITS-1:0] pass_left,
	input  logic signed [sts_pkg::SAMPLE_BITS-1:0] pass_right,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic signed [sts_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [sts_pkg::SAMPLE_BITS-1:0] right_out
);
	import sts_pkg::*;

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic                          load;

	assign load = ctl.lane_load | ctl.pass_load;

	// Request valid: set on load, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	// Payload select: processed lanes or bypass
	always_ff @(posedge clk) begin
		if (ctl.lane_load) begin
			left_q  <= lane_left;
			right_q <= lane_right;
		end else if (ctl.pass_load) begin
			left_q  <= pass_left;
			right_q <= pass_right;
		end
	end

	assign out_valid = valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;

endmodule

// ===== rtl/core/stereo_tape_saturator.sv =====
// Top level of the stereo tape saturator: config registers, knob gains, two lanes.
// Uses sts_pkg, sts_lane, sts_merge and stereo_tape_saturator_assert.svh.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------
//  in      | in_valid / in_stall  | left_in, right_in (signed 24)
//  out     | out_valid / out_stall| left_out, right_out (signed 24)
//  cfg     | cfg_valid / cfg_ready| cfg_index (2), cfg_data (16)
//
// Enabled: a frame runs through the step sequence around the one multiplier in each
// lane; no new frame is taken until the lanes' result moves to the output register.
// Bypassed: one frame per cycle while the output register drains.
// A new frame is taken while the previous result waits in the output register.
// Reset clears both low-pass states and loads enable=1, drive=level=half.
module stereo_tape_saturator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [sts_pkg::SAMPLE_BITS-1:0]  left_in,
	input  logic signed [sts_pkg::SAMPLE_BITS-1:0]  right_in,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [sts_pkg::SAMPLE_BITS-1:0]  left_out,
	output logic signed [sts_pkg::SAMPLE_BITS-1:0]  right_out,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic        [sts_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic        [sts_pkg::KNOB_BITS-1:0]    cfg_data
);
	import sts_pkg::*;

	`include "stereo_tape_saturator_assert.svh"

	logic                   enable_q;
	logic [KNOB_BITS-1:0]   drive_q;
	logic [KNOB_BITS-1:0]   level_q;
	logic [GAIN_W-1:0]      gain;
	logic [OGN_W-1:0]       ogn_s1;
	logic [OGN_W-1:0]       ogn_s2;
	logic [OGN_W+OGK_W-1:0] ogp_s2;
	logic [OG_W-1:0]        og_q;
	logic [OG_W-1:0]        og_q0;
	logic [OGN_W-1:0]       og_rem;

	sts_lane_ctl_t          lane_ctl;
	sts_lane_stat_t         l_stat;
	sts_lane_stat_t         r_stat;
	sts_merge_ctl_t         merge_ctl;
	logic signed [SAMPLE_BITS-1:0] l_y;
	logic signed [SAMPLE_BITS-1:0] r_y;

	logic in_acc;
	logic out_free;
	logic lanes_busy;
	logic lanes_done;
	logic take;

	assign cfg_ready = 1'b1;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			drive_q  <= KNOB_BITS'(longint'(1) << (KNOB_BITS - 1));
			level_q  <= KNOB_BITS'(longint'(1) << (KNOB_BITS - 1));
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_DRIVE:  drive_q  <= cfg_data;
				REG_LEVEL:  level_q  <= cfg_data;
				default:    enable_q <= enable_q;
			endcase
		end
	end

	// Drive gain 1 + 6*drive
	assign gain = GAIN_W'(longint'(1) << KNOB_BITS) + (GAIN_W'(drive_q) << 2)
		+ (GAIN_W'(drive_q) << 1);

	// Output gain: numerator, reciprocal multiply by 1/10, one correction step
	assign og_q0  = OG_W'(ogp_s2[OGN_W+OGK_W-1:OGN_W]);
	assign og_rem = ogn_s2 - (OGN_W'(og_q0) << 3) - (OGN_W'(og_q0) << 1);

	always_ff @(posedge clk) begin
		ogn_s1 <= OGN_W'(OG_BASE) + (OGN_W'(level_q) << 3) + (OGN_W'(level_q) << 2);
		ogp_s2 <= (OGN_W+OGK_W)'(ogn_s1) * (OGN_W+OGK_W)'(DIV10_K);
		ogn_s2 <= ogn_s1;
		og_q   <= (og_rem >= OGN_W'(OG_DIV)) ? og_q0 + OG_W'(1) : og_q0;
	end

	// Handshake control
	assign out_free   = !out_valid || !out_stall;
	assign lanes_busy = l_stat.busy | r_stat.busy;
	assign lanes_done = l_stat.done & r_stat.done;
	assign in_stall   = lanes_busy | l_stat.done | r_stat.done | (!enable_q && !out_free);
	assign in_acc     = in_valid && !in_stall;
	assign take       = lanes_done && out_free;

	assign lane_ctl.start      = in_acc && enable_q;
	assign lane_ctl.take       = take;
	assign merge_ctl.lane_load = take;
	assign merge_ctl.pass_load = in_acc && !enable_q;

	// Left and right lanes
	sts_lane u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.x      (left_in),
		.gain   (gain),
		.og     (og_q),
		.stat   (l_stat),
		.y      (l_y)
	);

	sts_lane u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.x      (right_in),
		.gain   (gain),
		.og     (og_q),
		.stat   (r_stat),
		.y      (r_y)
	);

	// Output register
	sts_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (merge_ctl),
		.lane_left  (l_y),
		.lane_right (r_y),
		.pass_left  (left_in),
		.pass_right (right_in),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.left_out   (left_out),
		.right_out  (right_out)
	);

	// Lanes run in lockstep
	`STS_ASSERT_IMPL(a_lockstep, clk, arst_n, 1'b1, l_stat == r_stat)
	// A started frame puts the lanes to work
	`STS_ASSERT_NEXT(a_start_busy, clk, arst_n, lane_ctl.start, l_stat.busy)
	// A finished result is held until the output stage takes it
	`STS_ASSERT_NEXT(a_done_hold, clk, arst_n, lanes_done && !out_free, lanes_done)
	// Taking a result always presents a request
	`STS_ASSERT_NEXT(a_take_valid, clk, arst_n, take, out_valid)

endmodule
